[rtl/cfbl_pkg.sv]
// ----------------------------------------------------------------------------
// cfbl_pkg
// Shared codes, widths and types of the coalescing free block list.
// ----------------------------------------------------------------------------
`default_nettype none

package cfbl_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int ADDR_WIDTH_DEF    = 32;

  // fixed port widths
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int FIELD_W    = 32;
  localparam int SIZE_OUT_W = 33;
  localparam int TOTAL_W    = 6;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIST    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ENTRY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // compare results of the shared unit
  typedef struct packed {
    logic cand_above;  // candidate start is above the base start
    logic adjoin;      // base block ends exactly at candidate start
  } cmp_flags_t;

endpackage

`default_nettype wire

[rtl/coalescing_free_block_list_top.sv]
// ----------------------------------------------------------------------------
// coalescing_free_block_list_top
// Address-ordered free block table with insert, release-and-merge and list.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. An insert,
// release or list that does work then keeps busy high until its last result
// word has been issued. Results appear on result_strobe for one cycle each
// and cannot be held off. An insert moves every entry above the new address
// up one slot, walking down from the top entry. A release that leaves m >= 2
// entries held after placing the block adds a merge pass over them; with a
// single entry held there is no pass. A list of n held entries issues n
// result words, one per cycle. A full-table drop, an empty list and an unused
// command leave busy low and answer in the cycle after the command is taken.
// The table memory gives one read and one write per cycle. Reset clears the
// state, the entry count and result_strobe; table contents need no clearing.
`default_nettype none

module coalescing_free_block_list_top #(
  parameter int TABLE_ENTRIES = cfbl_pkg::TABLE_ENTRIES_DEF,
  parameter int ADDR_WIDTH    = cfbl_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [cfbl_pkg::CMD_W-1:0]         command,
  input  wire logic [cfbl_pkg::FIELD_W-1:0]       block_addr,
  input  wire logic [cfbl_pkg::FIELD_W-1:0]       block_size,
  output logic                                    result_strobe,
  output logic      [cfbl_pkg::STATUS_W-1:0]      status,
  output logic      [cfbl_pkg::FIELD_W-1:0]       entry_addr,
  output logic      [cfbl_pkg::SIZE_OUT_W-1:0]    entry_size,
  output logic      [cfbl_pkg::TOTAL_W-1:0]       entry_total,
  output logic                                    last
);

  localparam int AIW = $clog2(TABLE_ENTRIES);
  localparam int CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int EW  = 2 * ADDR_WIDTH + 1;
  localparam int FW  = cfbl_pkg::FIELD_W;
  localparam int SW  = cfbl_pkg::SIZE_OUT_W;
  localparam int TW  = cfbl_pkg::TOTAL_W;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_INS_SHIFT = 7'b0000010,
    S_CO_PRIME  = 7'b0000100,
    S_CO_LOAD   = 7'b0001000,
    S_CO_RUN    = 7'b0010000,
    S_CO_FLUSH  = 7'b0100000,
    S_LIST_RUN  = 7'b1000000
  } state_t;

  state_t                  state, state_next;
  logic [CW-1:0]           count, count_next;
  logic [CW-1:0]           idx, idx_next;
  logic [CW-1:0]           rpos, rpos_next;
  logic [CW-1:0]           wpos, wpos_next;
  logic [cfbl_pkg::CMD_W-1:0] cmd;
  logic [ADDR_WIDTH-1:0]   op_addr;
  logic [ADDR_WIDTH:0]     op_size;
  logic [ADDR_WIDTH-1:0]   acc_start, acc_start_next;
  logic [ADDR_WIDTH:0]     acc_len, acc_len_next;

  logic                    accept;
  logic [ADDR_WIDTH+FW-1:0] addr_ext;
  logic [ADDR_WIDTH+FW-1:0] size_ext;

  // memory ports
  logic                    wr_en;
  logic [CW-1:0]           wr_pos;
  logic [EW-1:0]           wr_data;
  logic [CW-1:0]           rd_pos;
  logic [EW-1:0]           rd_data;
  logic [ADDR_WIDTH-1:0]   rd_start;
  logic [ADDR_WIDTH:0]     rd_len;

  // shared unit
  logic [ADDR_WIDTH-1:0]   alu_base;
  cfbl_pkg::cmp_flags_t    flags;
  logic [ADDR_WIDTH:0]     merged_len;

  // result word before its register
  logic                    emit_en;
  logic [cfbl_pkg::STATUS_W-1:0] emit_status;
  logic [ADDR_WIDTH-1:0]   emit_addr;
  logic [ADDR_WIDTH:0]     emit_size;
  logic [CW-1:0]           emit_total;
  logic                    emit_last;

  logic [ADDR_WIDTH+FW-1:0]  out_addr_ext;
  logic [ADDR_WIDTH+SW:0]    out_size_ext;
  logic [CW+TW-1:0]          out_total_ext;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign addr_ext = {{ADDR_WIDTH{1'b0}}, block_addr};
  assign size_ext = {{ADDR_WIDTH{1'b0}}, block_size};

  assign rd_start = rd_data[EW-1 -: ADDR_WIDTH];
  assign rd_len   = rd_data[ADDR_WIDTH:0];

  assign alu_base = (state == S_INS_SHIFT) ? op_addr : acc_start;

  cfbl_mem #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_pos[AIW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_pos[AIW-1:0]),
    .rd_data (rd_data)
  );

  cfbl_alu #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_alu (
    .base_start (alu_base),
    .base_len   (acc_len),
    .cand_start (rd_start),
    .cand_len   (rd_len),
    .flags      (flags),
    .merged_len (merged_len)
  );

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    rpos_next      = rpos;
    wpos_next      = wpos;
    acc_start_next = acc_start;
    acc_len_next   = acc_len;
    wr_en          = 1'b0;
    wr_pos         = idx;
    wr_data        = {op_addr, op_size};
    rd_pos         = '0;
    emit_en        = 1'b0;
    emit_status    = cfbl_pkg::ST_OK;
    emit_addr      = '0;
    emit_size      = '0;
    emit_total     = count;
    emit_last      = 1'b1;

    case (state)
      S_IDLE: begin
        // insert walks down from the top entry, list walks up from zero
        rd_pos = (command == cfbl_pkg::CMD_LIST) ? '0 : count - CW'(1);
        if (accept) begin
          case (command)
            cfbl_pkg::CMD_INSERT, cfbl_pkg::CMD_RELEASE: begin
              if (count == CW'(TABLE_ENTRIES)) begin
                emit_en     = 1'b1;
                emit_status = cfbl_pkg::ST_FULL;
              end else begin
                idx_next   = count;
                state_next = S_INS_SHIFT;
              end
            end
            cfbl_pkg::CMD_LIST: begin
              if (count == '0) begin
                emit_en     = 1'b1;
                emit_status = cfbl_pkg::ST_EMPTY;
              end else begin
                idx_next   = '0;
                state_next = S_LIST_RUN;
              end
            end
            default: begin
              emit_en = 1'b1;
            end
          endcase
        end
      end

      S_INS_SHIFT: begin
        rd_pos = idx - CW'(2);
        wr_en  = 1'b1;
        wr_pos = idx;
        if (idx != '0 && flags.cand_above) begin
          // entry below moves up one slot; equal addresses stop the walk
          wr_data  = rd_data;
          idx_next = idx - CW'(1);
        end else begin
          count_next = count + CW'(1);
          if (cmd == cfbl_pkg::CMD_RELEASE && count != '0) begin
            state_next = S_CO_PRIME;
          end else begin
            emit_en    = 1'b1;
            emit_total = count + CW'(1);
            state_next = S_IDLE;
          end
        end
      end

      S_CO_PRIME: begin
        rd_pos     = '0;
        state_next = S_CO_LOAD;
      end

      S_CO_LOAD: begin
        rd_pos         = CW'(1);
        acc_start_next = rd_start;
        acc_len_next   = rd_len;
        rpos_next      = CW'(1);
        wpos_next      = '0;
        state_next     = S_CO_RUN;
      end

      S_CO_RUN: begin
        // compaction: writes trail the reads, so no read sees a moved entry
        rd_pos = rpos + CW'(1);
        if (flags.adjoin) begin
          acc_len_next = merged_len;
        end else begin
          wr_en          = 1'b1;
          wr_pos         = wpos;
          wr_data        = {acc_start, acc_len};
          wpos_next      = wpos + CW'(1);
          acc_start_next = rd_start;
          acc_len_next   = rd_len;
        end
        rpos_next = rpos + CW'(1);
        if (rpos == count - CW'(1)) begin
          state_next = S_CO_FLUSH;
        end
      end

      S_CO_FLUSH: begin
        wr_en      = 1'b1;
        wr_pos     = wpos;
        wr_data    = {acc_start, acc_len};
        count_next = wpos + CW'(1);
        emit_en    = 1'b1;
        emit_total = wpos + CW'(1);
        state_next = S_IDLE;
      end

      S_LIST_RUN: begin
        rd_pos      = idx + CW'(1);
        idx_next    = idx + CW'(1);
        emit_en     = 1'b1;
        emit_status = cfbl_pkg::ST_ENTRY;
        emit_addr   = rd_start;
        emit_size   = rd_len;
        emit_last   = (idx == count - CW'(1));
        if (emit_last) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      result_strobe <= emit_en;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    rpos      <= rpos_next;
    wpos      <= wpos_next;
    acc_start <= acc_start_next;
    acc_len   <= acc_len_next;
    if (accept) begin
      cmd     <= command;
      op_addr <= addr_ext[ADDR_WIDTH-1:0];
      op_size <= {1'b0, size_ext[ADDR_WIDTH-1:0]};
    end
  end

  assign out_addr_ext  = {{FW{1'b0}}, emit_addr};
  assign out_size_ext  = {{SW{1'b0}}, emit_size};
  assign out_total_ext = {{TW{1'b0}}, emit_total};

  always_ff @(posedge clk) begin
    if (emit_en) begin
      status      <= emit_status;
      entry_addr  <= out_addr_ext[FW-1:0];
      entry_size  <= out_size_ext[SW-1:0];
      entry_total <= out_total_ext[TW-1:0];
      last        <= emit_last;
    end
  end

endmodule

`default_nettype wire

[rtl/cfbl_mem.sv]
// ----------------------------------------------------------------------------
// cfbl_mem
// Block table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfbl_mem #(
  parameter int DEPTH = cfbl_pkg::TABLE_ENTRIES_DEF,
  parameter int WIDTH = 2 * cfbl_pkg::ADDR_WIDTH_DEF + 1
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/cfbl_alu.sv]
// ----------------------------------------------------------------------------
// cfbl_alu
// Shared compare and add unit: address order, adjacency and merged size.
// ----------------------------------------------------------------------------
`default_nettype none

module cfbl_alu #(
  parameter int ADDR_WIDTH = cfbl_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic [ADDR_WIDTH-1:0] base_start,
  input  wire logic [ADDR_WIDTH:0]   base_len,
  input  wire logic [ADDR_WIDTH-1:0] cand_start,
  input  wire logic [ADDR_WIDTH:0]   cand_len,
  output cfbl_pkg::cmp_flags_t       flags,
  output logic      [ADDR_WIDTH:0]   merged_len
);

  logic [ADDR_WIDTH+1:0] end_sum;

  // end is one bit wider than the size, so it never wraps
  assign end_sum          = {2'b00, base_start} + {1'b0, base_len};
  assign flags.adjoin     = (end_sum == {2'b00, cand_start});
  assign flags.cand_above = (cand_start > base_start);
  assign merged_len       = base_len + cand_len;

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the coalescing free block list against a cycle-free table model:
// directed corner cases, carved address ranges sent in random order with
// holes and stray blocks, then a full table. Every result word is compared.
// ----------------------------------------------------------------------------

module tb_top;

  import cfbl_pkg::*;

  localparam int TABLE_DEPTH  = TABLE_ENTRIES_DEF;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 80;

  // command 3 has no name in the package; the block answers it and changes nothing
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [STATUS_W-1:0]   status;
    logic [FIELD_W-1:0]    addr;
    logic [SIZE_OUT_W-1:0] size;
    logic [TOTAL_W-1:0]    total;
    logic                  last;
  } table_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [CMD_W-1:0]      command = CMD_INSERT;
  logic [FIELD_W-1:0]    block_addr = '0;
  logic [FIELD_W-1:0]    block_size = '0;
  logic                  result_strobe;
  logic [STATUS_W-1:0]   status;
  logic [FIELD_W-1:0]    entry_addr;
  logic [SIZE_OUT_W-1:0] entry_size;
  logic [TOTAL_W-1:0]    entry_total;
  logic                  last;

  // model of the free table
  logic [FIELD_W-1:0]    free_start [TABLE_DEPTH];
  logic [SIZE_OUT_W-1:0] free_length [TABLE_DEPTH];
  int                    free_held = 0;

  table_report_t table_reports_q[$];
  int            error_count = 0;
  int            sent_count = 0;
  bit            idle_on = 1'b1;
  int            stall_cycles = 0;

  coalescing_free_block_list_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .block_addr   (block_addr),
    .block_size   (block_size),
    .result_strobe(result_strobe),
    .status       (status),
    .entry_addr   (entry_addr),
    .entry_size   (entry_size),
    .entry_total  (entry_total),
    .last         (last)
  );

  always #5 clk = ~clk;

  function automatic void push_report(logic [STATUS_W-1:0] st, logic [FIELD_W-1:0] a,
                                      logic [SIZE_OUT_W-1:0] s, logic lst);
    table_report_t r;
    r.status = st;
    r.addr   = a;
    r.size   = s;
    r.total  = free_held[TOTAL_W-1:0];
    r.last   = lst;
    table_reports_q.push_back(r);
  endfunction

  function automatic void apply_table_command(logic [CMD_W-1:0] cmd, logic [FIELD_W-1:0] a,
                                              logic [FIELD_W-1:0] s);
    int          pos;
    int          i;
    int          cur;
    logic [33:0] block_end;
    case (cmd)
      CMD_INSERT, CMD_RELEASE: begin
        if (free_held >= TABLE_DEPTH) begin
          push_report(ST_FULL, '0, '0, 1'b1);
        end else begin
          // ties on address go behind the existing entries
          pos = 0;
          while (pos < free_held && free_start[pos] <= a) pos++;
          for (i = free_held; i > pos; i--) begin
            free_start[i]  = free_start[i-1];
            free_length[i] = free_length[i-1];
          end
          free_start[pos]  = a;
          free_length[pos] = {1'b0, s};
          free_held++;
          if (cmd == CMD_RELEASE) begin
            // single pass; stays on an entry after merging into it
            cur = 0;
            while (cur + 1 < free_held) begin
              block_end = {2'b0, free_start[cur]} + {1'b0, free_length[cur]};
              if (block_end == {2'b0, free_start[cur+1]}) begin
                free_length[cur] = free_length[cur] + free_length[cur+1];
                for (i = cur + 1; i + 1 < free_held; i++) begin
                  free_start[i]  = free_start[i+1];
                  free_length[i] = free_length[i+1];
                end
                free_held--;
              end else begin
                cur++;
              end
            end
          end
          push_report(ST_OK, '0, '0, 1'b1);
        end
      end
      CMD_LIST: begin
        if (free_held == 0) begin
          push_report(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (i = 0; i < free_held; i++)
            push_report(ST_ENTRY, free_start[i], free_length[i], i + 1 == free_held);
        end
      end
      default: begin
        push_report(ST_OK, '0, '0, 1'b1);
      end
    endcase
  endfunction

  // smallest hole between two neighbors; filling it merges them
  function automatic bit find_gap(output logic [FIELD_W-1:0] fill_addr,
                                  output logic [FIELD_W-1:0] fill_size);
    logic [33:0] block_end;
    logic [33:0] best;
    bit          found;
    int          i;
    found = 1'b0;
    best  = '1;
    for (i = 0; i + 1 < free_held; i++) begin
      block_end = {2'b0, free_start[i]} + {1'b0, free_length[i]};
      if (block_end < {2'b0, free_start[i+1]} &&
          {2'b0, free_start[i+1]} - block_end < best) begin
        best      = {2'b0, free_start[i+1]} - block_end;
        fill_addr = block_end[FIELD_W-1:0];
        fill_size = best[FIELD_W-1:0];
        found     = 1'b1;
      end
    end
    return found;
  endfunction

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [FIELD_W-1:0] a,
                           logic [FIELD_W-1:0] s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start      <= 1'b1;
    command    <= cmd;
    block_addr <= a;
    block_size <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_table_command(cmd, a, s);
    sent_count++;
  endtask

  task automatic test_empty_and_unused();
    send_word(CMD_LIST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_wide_merge();
    send_word(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(CMD_LIST, 32'h0, 32'h0);
    // zero-size word ties at the top; the two big blocks merge past 32 bits
    send_word(CMD_RELEASE, 32'hFFFF_FFFF, 32'h0);
    // merged end truncated to 32 bits would equal this start
    send_word(CMD_RELEASE, 32'hFFFF_FFFE, 32'h1);
    send_word(CMD_LIST, 32'h0, 32'h0);
  endtask

  task automatic test_order_and_ties();
    send_word(CMD_INSERT, 32'h100, 32'h100);
    send_word(CMD_INSERT, 32'h200, 32'h80);
    send_word(CMD_INSERT, 32'h100, 32'h40);
    send_word(CMD_INSERT, 32'h20, 32'hE0);
    send_word(CMD_LIST, 32'h0, 32'h0);
    send_word(CMD_RELEASE, 32'h280, 32'h80);
    send_word(CMD_UNUSED, $urandom, $urandom);
    send_word(CMD_LIST, $urandom, $urandom);
  endtask

  // contiguous ranges carved into pieces, sent shuffled, sometimes with a hole
  task automatic test_random_traffic();
    logic [63:0]        carve_point;
    logic [FIELD_W-1:0] piece_addr [8];
    logic [FIELD_W-1:0] piece_size [8];
    logic [FIELD_W-1:0] fill_addr;
    logic [FIELD_W-1:0] fill_size;
    int                 order [8];
    int                 n_pieces;
    int                 hole;
    int                 stray_left;
    int                 k;
    int                 j;
    int                 tmp;
    carve_point = 64'h1000;
    stray_left  = 6;
    while (sent_count < 350 && carve_point < 64'hE000_0000) begin
      idle_on = ($urandom_range(0, 2) != 0);
      while (free_held > 18 && find_gap(fill_addr, fill_size))
        send_word(CMD_RELEASE, fill_addr, fill_size);
      if ($urandom_range(0, 3) == 0) carve_point += $urandom_range(1, 1 << 28);
      n_pieces = $urandom_range(2, 8);
      for (k = 0; k < n_pieces; k++) begin
        piece_addr[k] = carve_point[FIELD_W-1:0];
        piece_size[k] = $urandom_range(1, 1 << $urandom_range(0, 24));
        carve_point  += piece_size[k];
        order[k]      = k;
      end
      for (k = n_pieces - 1; k > 0; k--) begin
        j        = $urandom_range(0, k);
        tmp      = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
      hole = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n_pieces - 1) : -1;
      for (k = 0; k < n_pieces; k++) begin
        if (order[k] != hole)
          send_word(($urandom_range(0, 2) != 0) ? CMD_RELEASE : CMD_INSERT,
                    piece_addr[order[k]], piece_size[order[k]]);
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 3))
          0: send_word(CMD_LIST, $urandom, $urandom);
          1: send_word(CMD_UNUSED, $urandom, $urandom);
          default: begin
            if (stray_left > 0) begin
              stray_left--;
              send_word(($urandom_range(0, 1) != 0) ? CMD_RELEASE : CMD_INSERT,
                        $urandom, $urandom);
            end
          end
        endcase
      end
    end
  endtask

  task automatic test_full_table();
    logic [FIELD_W-1:0] fill_addr;
    logic [FIELD_W-1:0] fill_size;
    idle_on = 1'b0;
    while (free_held < TABLE_DEPTH)
      send_word(CMD_INSERT, $urandom, $urandom_range(0, 4095));
    send_word(CMD_INSERT, $urandom, $urandom);
    // dropped even though it would merge
    if (find_gap(fill_addr, fill_size)) send_word(CMD_RELEASE, fill_addr, fill_size);
    else send_word(CMD_RELEASE, $urandom, $urandom);
    send_word(CMD_LIST, $urandom, $urandom);
    send_word(CMD_UNUSED, $urandom, $urandom);
    repeat (6) send_word(CMD_W'($urandom_range(CMD_INSERT, CMD_UNUSED)), $urandom, $urandom);
  endtask

  always @(posedge clk) begin : check_results
    table_report_t want;
    if (!rst && result_strobe) begin
      if (table_reports_q.size() == 0) begin
        $error("result word with none expected: status %0d addr %h", status, entry_addr);
        error_count++;
      end else begin
        want = table_reports_q.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          error_count++;
        end
        if (entry_addr !== want.addr) begin
          $error("entry_addr: expected %h, got %h", want.addr, entry_addr);
          error_count++;
        end
        if (entry_size !== want.size) begin
          $error("entry_size: expected %h, got %h", want.size, entry_size);
          error_count++;
        end
        if (entry_total !== want.total) begin
          $error("entry_total: expected %0d, got %0d", want.total, entry_total);
          error_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || result_strobe) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_unused();
    test_wide_merge();
    test_order_and_ties();
    test_random_traffic();
    test_full_table();
    start <= 1'b0;
    while (table_reports_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
rtl/cfbl_pkg.sv
rtl/cfbl_mem.sv
rtl/cfbl_alu.sv
rtl/coalescing_free_block_list_top.sv
test/tb_top.sv
